@@ design/smkvp_pkg.sv @@
package smkvp_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_UP_V   = 8'h56;

  localparam logic [3:0] IDX_B  = 4'd0;
  localparam logic [3:0] IDX_V  = 4'd1;
  localparam logic [3:0] IDX_F  = 4'd2;
  localparam logic [3:0] IDX_N  = 4'd3;
  localparam logic [3:0] IDX_A2 = 4'd4;
  localparam logic [3:0] IDX_DB = 4'd8;
  localparam logic [3:0] IDX_DV = 4'd9;
  localparam logic [3:0] IDX_A0 = 4'd10;
  localparam logic [3:0] IDX_A1 = 4'd11;
  localparam logic [3:0] IDX_LAST = IDX_A1;

  localparam logic [1:0] KEY_LEN_MAX = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } smkvp_match_t;

  function automatic smkvp_match_t match_key(input logic [1:0] len,
                                             input logic [7:0] a,
                                             input logic [7:0] b);
    smkvp_match_t m;
    m.hit = 1'b0;
    m.idx = IDX_B;
    case (len)
      2'd0: begin
        m.hit = 1'b1;
        m.idx = IDX_B;
      end
      2'd1: begin
        m.hit = 1'b1;
        case (a)
          CH_LOW_B: m.idx = IDX_B;
          CH_LOW_V: m.idx = IDX_V;
          CH_LOW_F: m.idx = IDX_F;
          CH_LOW_N: m.idx = IDX_N;
          CH_UP_A:  m.idx = IDX_A2;
          CH_UP_D:  m.idx = IDX_DB;
          default: begin
            m.hit = 1'b0;
            m.idx = IDX_B;
          end
        endcase
      end
      2'd2: begin
        if (a == CH_UP_A) begin
          if (b >= CH_TWO && b <= CH_FIVE) begin
            m.hit = 1'b1;
            m.idx = IDX_A2 + 4'(b - CH_TWO);
          end else if (b == CH_ZERO) begin
            m.hit = 1'b1;
            m.idx = IDX_A0;
          end else if (b == CH_ONE) begin
            m.hit = 1'b1;
            m.idx = IDX_A1;
          end
        end else if (a == CH_UP_D) begin
          if (b == CH_UP_B) begin
            m.hit = 1'b1;
            m.idx = IDX_DB;
          end else if (b == CH_UP_V) begin
            m.hit = 1'b1;
            m.idx = IDX_DV;
          end
        end
      end
      default: begin
        m.hit = 1'b0;
        m.idx = IDX_B;
      end
    endcase
    return m;
  endfunction

endpackage

@@ design/setup_message_key_value_parser.sv @@
// Parses a setup line of the form {"key":v,...} one byte per beat and returns one result
// beat for every input beat, in the next cycle, at one byte per cycle while out_ready is
// high; the only storage is the parse phase, the first two key bytes, a saturating key
// length and the result register. A result beat flags an update when its byte was the
// value of a recognised key (b, v, f, n, A0..A5, DB, DV, with one-letter prefixes A and D
// and the empty key accepted), giving the setting index and the value byte as signed 8-bit
// minus 48. A byte marked end of message returns the parser to idle after it is handled.
module setup_message_key_value_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_byte,
  input  logic              in_end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_update_valid,
  output logic [3:0]        out_setting_index,
  output logic signed [8:0] out_setting_value
);

  typedef enum logic [2:0] {
    PH_OUTSIDE,
    PH_KEY,
    PH_SKIP_ONE,
    PH_VALUE,
    PH_TAIL
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        key_first_r, key_first_nxt;
  logic [7:0]        key_second_r, key_second_nxt;
  logic [1:0]        key_len_r, key_len_nxt;
  logic              out_valid_r;
  logic              upd_r, upd_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic signed [8:0] val_r, val_nxt;

  smkvp_pkg::smkvp_match_t match;
  logic                    in_acc;
  logic                    is_end;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign is_end   = (in_char_byte == smkvp_pkg::CH_COMMA) ||
                    (in_char_byte == smkvp_pkg::CH_RBRACE);
  assign match    = smkvp_pkg::match_key(key_len_r, key_first_r, key_second_r);

  always_comb begin
    phase_nxt      = phase_r;
    key_first_nxt  = key_first_r;
    key_second_nxt = key_second_r;
    key_len_nxt    = key_len_r;
    upd_nxt        = 1'b0;
    idx_nxt        = smkvp_pkg::IDX_B;
    val_nxt        = '0;
    case (phase_r)
      PH_OUTSIDE: begin
        if (in_char_byte == smkvp_pkg::CH_QUOTE) begin
          phase_nxt      = PH_KEY;
          key_first_nxt  = '0;
          key_second_nxt = '0;
          key_len_nxt    = '0;
        end
      end
      PH_KEY: begin
        if (in_char_byte == smkvp_pkg::CH_QUOTE) begin
          phase_nxt = PH_SKIP_ONE;
        end else begin
          if (key_len_r == 2'd0) key_first_nxt = in_char_byte;
          if (key_len_r == 2'd1) key_second_nxt = in_char_byte;
          if (key_len_r != smkvp_pkg::KEY_LEN_MAX) key_len_nxt = key_len_r + 2'd1;
        end
      end
      PH_SKIP_ONE: begin
        phase_nxt = PH_VALUE;
      end
      PH_VALUE: begin
        if (match.hit) begin
          upd_nxt = 1'b1;
          idx_nxt = match.idx;
          val_nxt = $signed({in_char_byte[7], in_char_byte}) -
                    $signed({1'b0, smkvp_pkg::CH_ZERO});
        end
        phase_nxt = is_end ? PH_OUTSIDE : PH_TAIL;
      end
      PH_TAIL: begin
        if (is_end) phase_nxt = PH_OUTSIDE;
      end
      default: begin
        phase_nxt = PH_OUTSIDE;
      end
    endcase
    if (in_end_of_message) phase_nxt = PH_OUTSIDE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OUTSIDE;
      key_first_r  <= '0;
      key_second_r <= '0;
      key_len_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r      <= phase_nxt;
        key_first_r  <= key_first_nxt;
        key_second_r <= key_second_nxt;
        key_len_r    <= key_len_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      upd_r <= upd_nxt;
      idx_r <= idx_nxt;
      val_r <= val_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_update_valid  = upd_r;
  assign out_setting_index = idx_r;
  assign out_setting_value = val_r;

  // a non-update beat always carries a zero payload
  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !upd_r) |-> (idx_r == smkvp_pkg::IDX_B && val_r == 9'sd0))
    else $error("non-update beat with nonzero payload");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && upd_r) |-> (idx_r <= smkvp_pkg::IDX_LAST))
    else $error("setting index out of range");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_message) |=> (phase_r == PH_OUTSIDE))
    else $error("parser not idle after end of message");

  a_skip_to_value: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_SKIP_ONE) |=>
      (phase_r == PH_VALUE || phase_r == PH_OUTSIDE))
    else $error("skipped byte not followed by value phase");

  a_update_from_value: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r != PH_VALUE) |=> !upd_r)
    else $error("update outside value phase");

endmodule
